>>> hdl/dgsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dense graph shortest path core.
// Used by every module under hdl/ but dgsp_adj_mem; depends on nothing else.

package dgsp_pkg;

  // Fixed widths of the port fields
  localparam int DIST_BITS       = 20;
  localparam int PORT_VERT_BITS  = 4;
  localparam int PORT_WEIGHT_BITS = 16;
  localparam int ACTIVE_BITS     = 5;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_CNT_BITS    = 5;

  localparam logic [DIST_BITS-1:0]   DIST_INF      = '1;
  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET  = 5'd16;

  // Request codes on req_type
  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_AB,
    ST_WR_BA,
    ST_INIT,
    ST_RELAX,
    ST_DRAIN,
    ST_FIN_RD,
    ST_FIN_CHK,
    ST_TR_PUSH,
    ST_TR_WAIT,
    ST_EM_RD,
    ST_EM_OUT,
    ST_MISS
  } seq_state_e;

  // Result of one relax step of the shared unit
  typedef struct packed {
    logic                 upd;
    logic                 take;
    logic [DIST_BITS-1:0] dval;
  } relax_t;

  // One result word handed from the sequencer to the output register
  typedef struct packed {
    logic                      valid;
    logic [PORT_VERT_BITS-1:0] vertex;
    logic [DIST_BITS-1:0]      total;
    logic                      reach;
    logic                      last;
  } emit_t;

endpackage

>>> hdl/dgsp_adj_mem.sv
`timescale 1ns / 1ps
// Adjacency weight memory with its own clearing sweep.
// Depends on nothing but its parameters; instanced by the top level.

module dgsp_adj_mem #(
  parameter int VW = 4,
  parameter int WB = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_start_i,
  output logic            busy_o,
  input  logic            we_i,
  input  logic [2*VW-1:0] waddr_i,
  input  logic [WB-1:0]   wdata_i,
  input  logic            re_i,
  input  logic [2*VW-1:0] raddr_i,
  output logic [WB-1:0]   rdata_o
);

  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;

  logic [WB-1:0] mem [DEPTH];
  logic [WB-1:0] rdata_q;
  logic          busy_q, busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // Sweep control: reset and clear requests zero every row and column
  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_start_i) begin
      busy_d     = 1'b1;
      clr_addr_d = '0;
    end else if (busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      busy_d     = ~(&clr_addr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // One write port (sweep wins), one registered read port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

>>> hdl/dgsp_relax_unit.sv
`timescale 1ns / 1ps
// Shared saturating add / compare unit: one edge relaxation and the
// running minimum pick per use. Depends on dgsp_pkg.

module dgsp_relax_unit #(
  parameter int WB = 16
) (
  input  logic [dgsp_pkg::DIST_BITS-1:0] du_i,
  input  logic [WB-1:0]                  w_i,
  input  logic [dgsp_pkg::DIST_BITS-1:0] dv_i,
  input  logic                           vis_i,
  input  logic [dgsp_pkg::DIST_BITS-1:0] best_i,
  output dgsp_pkg::relax_t               res_o
);

  localparam int DB = dgsp_pkg::DIST_BITS;

  logic [DB:0]   sum;
  logic [DB-1:0] sat;
  logic          upd;
  logic [DB-1:0] nd;

  // Saturating candidate distance through u
  assign sum = {1'b0, du_i} + (DB + 1)'(w_i);
  assign sat = sum[DB] ? dgsp_pkg::DIST_INF : sum[DB-1:0];

  assign upd = ~vis_i && (w_i != '0) && (du_i != dgsp_pkg::DIST_INF) && (sat < dv_i);
  assign nd  = upd ? sat : dv_i;

  // Minimum pick for the next round; later index wins a tie
  assign res_o.upd  = upd;
  assign res_o.dval = nd;
  assign res_o.take = ~vis_i && (nd <= best_i);

endmodule

>>> hdl/dgsp_seq.sv
`timescale 1ns / 1ps
// Sequencer of the shortest path core: request decode, Dijkstra rounds,
// path trace and result emission. Depends on dgsp_pkg and dgsp_relax_unit.

module dgsp_seq #(
  parameter int NUM_VERTICES = 16,
  parameter int WB           = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [dgsp_pkg::ACTIVE_BITS-1:0]        active_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [1:0]                              req_type_i,
  input  logic [dgsp_pkg::PORT_VERT_BITS-1:0]     vertex_a_i,
  input  logic [dgsp_pkg::PORT_VERT_BITS-1:0]     vertex_b_i,
  input  logic [dgsp_pkg::PORT_WEIGHT_BITS-1:0]   weight_i,
  // adjacency memory
  input  logic                                    adj_busy_i,
  output logic                                    adj_clr_o,
  output logic                                    adj_we_o,
  output logic [2*$clog2(NUM_VERTICES)-1:0]       adj_waddr_o,
  output logic [WB-1:0]                           adj_wdata_o,
  output logic                                    adj_re_o,
  output logic [2*$clog2(NUM_VERTICES)-1:0]       adj_raddr_o,
  input  logic [WB-1:0]                           adj_rdata_i,
  // result words
  output dgsp_pkg::emit_t                         emit_o,
  input  logic                                    emit_take_i
);

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int CW = $clog2(NUM_VERTICES + 1);
  localparam int DB = dgsp_pkg::DIST_BITS;
  localparam int KW = dgsp_pkg::RES_CNT_BITS;

  dgsp_pkg::seq_state_e state_q, state_d;

  logic [VW-1:0] src_q, src_d, dst_q, dst_d;
  logic [VW-1:0] a_q, a_d, b_q, b_d;
  logic [WB-1:0] w_q, w_d;
  logic [CW-1:0] nv_q, nv_d;
  logic [VW-1:0] nvm1_q, nvm1_d;
  logic [VW-1:0] v_q, v_d, r_q, r_d;
  logic          p1_q, p1_d;
  logic [VW-1:0] p1_v_q, p1_v_d;
  logic [VW-1:0] u_q, u_d, cand_q, cand_d;
  logic [DB-1:0] du_q, du_d, best_q, best_d, total_q, total_d;
  logic [NUM_VERTICES-1:0] visited_q, visited_d;
  logic [VW-1:0] x_q, x_d;
  logic [CW-1:0] n_q, n_d;
  logic [KW-1:0] cnt_q, cnt_d, k_q, k_d;

  // Per-vertex stores
  logic [DB-1:0] dist_mem  [NUM_VERTICES];
  logic [VW-1:0] pred_mem  [NUM_VERTICES];
  logic [VW-1:0] stack_mem [NUM_VERTICES];
  logic [DB-1:0] dist_rd_q;
  logic [VW-1:0] pred_rd_q, stack_rd_q;

  logic          dist_we, dist_re, pred_we, pred_re, stack_we, stack_re;
  logic [VW-1:0] dist_waddr, dist_raddr, pred_waddr, stack_waddr, stack_raddr;
  logic [DB-1:0] dist_wdata;
  logic [VW-1:0] pred_wdata;

  logic          in_acc, set_ok, q_ok, v_last, tr_done, em_last, rounds_done;
  logic [CW-1:0] nv_new, n_inc;
  logic [DB-1:0] best_nx;
  logic [VW-1:0] cand_nx;
  dgsp_pkg::relax_t rx;

  // Effective vertex count from the register
  always_comb begin
    if (active_i == '0) begin
      nv_new = CW'(1);
    end else if (32'(active_i) > NUM_VERTICES) begin
      nv_new = CW'(NUM_VERTICES);
    end else begin
      nv_new = CW'(active_i);
    end
  end

  assign in_acc      = in_valid_i && (state_q == dgsp_pkg::ST_IDLE);
  assign in_stall_o  = (state_q != dgsp_pkg::ST_IDLE);
  assign set_ok      = (32'(vertex_a_i) < NUM_VERTICES) && (32'(vertex_b_i) < NUM_VERTICES);
  assign q_ok        = (32'(vertex_a_i) < 32'(nv_new)) && (32'(vertex_b_i) < 32'(nv_new));
  assign v_last      = (v_q == nvm1_q);
  assign rounds_done = ((r_q + VW'(1)) == nvm1_q);
  assign n_inc       = n_q + CW'(1);
  assign tr_done     = (x_q == src_q) || (n_inc == nv_q);
  assign em_last     = ((k_q + KW'(1)) == cnt_q);

  // Shared relax / minimum unit, fed from stage one of the round pipeline
  dgsp_relax_unit #(
    .WB (WB)
  ) u_relax (
    .du_i   (du_q),
    .w_i    (adj_rdata_i),
    .dv_i   (dist_rd_q),
    .vis_i  (visited_q[p1_v_q]),
    .best_i (best_q),
    .res_o  (rx)
  );

  assign best_nx = (p1_q && rx.take) ? rx.dval : best_q;
  assign cand_nx = (p1_q && rx.take) ? p1_v_q : cand_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dgsp_pkg::ST_CLEAR: begin
        if (!adj_busy_i) state_d = dgsp_pkg::ST_IDLE;
      end
      dgsp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            dgsp_pkg::REQ_SET:   state_d = set_ok ? dgsp_pkg::ST_WR_AB : dgsp_pkg::ST_IDLE;
            dgsp_pkg::REQ_CLEAR: state_d = dgsp_pkg::ST_CLEAR;
            dgsp_pkg::REQ_QUERY: state_d = q_ok ? dgsp_pkg::ST_INIT : dgsp_pkg::ST_MISS;
            default:             state_d = dgsp_pkg::ST_IDLE;
          endcase
        end
      end
      dgsp_pkg::ST_WR_AB: state_d = dgsp_pkg::ST_WR_BA;
      dgsp_pkg::ST_WR_BA: state_d = dgsp_pkg::ST_IDLE;
      dgsp_pkg::ST_INIT: begin
        if (v_last) begin
          state_d = (nvm1_q == '0) ? dgsp_pkg::ST_FIN_RD : dgsp_pkg::ST_RELAX;
        end
      end
      dgsp_pkg::ST_RELAX: begin
        if (v_last) state_d = dgsp_pkg::ST_DRAIN;
      end
      dgsp_pkg::ST_DRAIN: begin
        state_d = rounds_done ? dgsp_pkg::ST_FIN_RD : dgsp_pkg::ST_RELAX;
      end
      dgsp_pkg::ST_FIN_RD: state_d = dgsp_pkg::ST_FIN_CHK;
      dgsp_pkg::ST_FIN_CHK: begin
        state_d = (dist_rd_q == dgsp_pkg::DIST_INF) ? dgsp_pkg::ST_MISS
                                                    : dgsp_pkg::ST_TR_PUSH;
      end
      dgsp_pkg::ST_TR_PUSH: state_d = tr_done ? dgsp_pkg::ST_EM_RD : dgsp_pkg::ST_TR_WAIT;
      dgsp_pkg::ST_TR_WAIT: state_d = dgsp_pkg::ST_TR_PUSH;
      dgsp_pkg::ST_EM_RD:   state_d = dgsp_pkg::ST_EM_OUT;
      dgsp_pkg::ST_EM_OUT: begin
        if (emit_take_i) state_d = em_last ? dgsp_pkg::ST_IDLE : dgsp_pkg::ST_EM_RD;
      end
      dgsp_pkg::ST_MISS: begin
        if (emit_take_i) state_d = dgsp_pkg::ST_IDLE;
      end
      default: state_d = dgsp_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and result word
  always_comb begin
    adj_clr_o   = 1'b0;
    adj_we_o    = 1'b0;
    adj_waddr_o = {a_q, b_q};
    adj_wdata_o = w_q;
    adj_re_o    = 1'b0;
    adj_raddr_o = {u_q, v_q};
    dist_we     = 1'b0;
    dist_waddr  = v_q;
    dist_wdata  = (v_q == src_q) ? '0 : dgsp_pkg::DIST_INF;
    dist_re     = 1'b0;
    dist_raddr  = v_q;
    pred_we     = 1'b0;
    pred_waddr  = v_q;
    pred_wdata  = src_q;
    pred_re     = 1'b0;
    stack_we    = 1'b0;
    stack_waddr = VW'(n_q);
    stack_re    = 1'b0;
    stack_raddr = VW'(32'(n_q) - 32'(k_q) - 32'd1);
    emit_o      = '0;
    unique case (state_q)
      dgsp_pkg::ST_IDLE: begin
        adj_clr_o = in_acc && (req_type_i == dgsp_pkg::REQ_CLEAR);
      end
      dgsp_pkg::ST_WR_AB: adj_we_o = 1'b1;
      dgsp_pkg::ST_WR_BA: begin
        adj_we_o    = 1'b1;
        adj_waddr_o = {b_q, a_q};
      end
      dgsp_pkg::ST_INIT: begin
        dist_we = 1'b1;
        pred_we = 1'b1;
      end
      dgsp_pkg::ST_RELAX: begin
        adj_re_o = 1'b1;
        dist_re  = 1'b1;
      end
      dgsp_pkg::ST_FIN_RD: begin
        dist_re    = 1'b1;
        dist_raddr = dst_q;
      end
      dgsp_pkg::ST_TR_PUSH: begin
        stack_we = 1'b1;
        pred_re  = ~tr_done;
      end
      dgsp_pkg::ST_EM_RD: stack_re = 1'b1;
      dgsp_pkg::ST_EM_OUT: begin
        emit_o.valid  = 1'b1;
        emit_o.vertex = dgsp_pkg::PORT_VERT_BITS'(stack_rd_q);
        emit_o.total  = total_q;
        emit_o.reach  = 1'b1;
        emit_o.last   = em_last;
      end
      dgsp_pkg::ST_MISS: begin
        emit_o.valid = 1'b1;
        emit_o.total = dgsp_pkg::DIST_INF;
        emit_o.last  = 1'b1;
      end
      default: ;
    endcase
    // stage one write-back of a relaxed distance
    if (p1_q && rx.upd) begin
      dist_we    = 1'b1;
      dist_waddr = p1_v_q;
      dist_wdata = rx.dval;
      pred_we    = 1'b1;
      pred_waddr = p1_v_q;
      pred_wdata = u_q;
    end
  end

  // Datapath next values
  always_comb begin
    src_d     = src_q;
    dst_d     = dst_q;
    a_d       = a_q;
    b_d       = b_q;
    w_d       = w_q;
    nv_d      = nv_q;
    nvm1_d    = nvm1_q;
    v_d       = v_q;
    r_d       = r_q;
    p1_d      = (state_q == dgsp_pkg::ST_RELAX);
    p1_v_d    = v_q;
    u_d       = u_q;
    du_d      = du_q;
    best_d    = best_nx;
    cand_d    = cand_nx;
    visited_d = visited_q;
    total_d   = total_q;
    x_d       = x_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    unique case (state_q)
      dgsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          a_d       = VW'(vertex_a_i);
          b_d       = VW'(vertex_b_i);
          src_d     = VW'(vertex_a_i);
          dst_d     = VW'(vertex_b_i);
          w_d       = WB'(weight_i);
          nv_d      = nv_new;
          nvm1_d    = VW'(nv_new - CW'(1));
          v_d       = '0;
          visited_d = '0;
        end
      end
      dgsp_pkg::ST_INIT: begin
        v_d = v_q + VW'(1);
        if (v_last) begin
          v_d            = '0;
          r_d            = '0;
          u_d            = src_q;
          du_d           = '0;
          best_d         = dgsp_pkg::DIST_INF;
          cand_d         = '0;
          visited_d[src_q] = 1'b1;
        end
      end
      dgsp_pkg::ST_RELAX: begin
        v_d = v_last ? '0 : (v_q + VW'(1));
      end
      dgsp_pkg::ST_DRAIN: begin
        u_d              = cand_nx;
        du_d             = best_nx;
        best_d           = dgsp_pkg::DIST_INF;
        cand_d           = '0;
        r_d              = r_q + VW'(1);
        visited_d[cand_nx] = 1'b1;
      end
      dgsp_pkg::ST_FIN_CHK: begin
        total_d = dist_rd_q;
        x_d     = dst_q;
        n_d     = '0;
      end
      dgsp_pkg::ST_TR_PUSH: begin
        n_d = n_inc;
        k_d = '0;
        if (32'(n_inc) > dgsp_pkg::MAX_RESULTS) begin
          cnt_d = KW'(dgsp_pkg::MAX_RESULTS);
        end else begin
          cnt_d = KW'(n_inc);
        end
      end
      dgsp_pkg::ST_TR_WAIT: x_d = pred_rd_q;
      dgsp_pkg::ST_EM_OUT: begin
        if (emit_take_i) k_d = k_q + KW'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dgsp_pkg::ST_CLEAR;
      p1_q      <= 1'b0;
      visited_q <= '0;
    end else begin
      state_q   <= state_d;
      p1_q      <= p1_d;
      visited_q <= visited_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    dst_q   <= dst_d;
    a_q     <= a_d;
    b_q     <= b_d;
    w_q     <= w_d;
    nv_q    <= nv_d;
    nvm1_q  <= nvm1_d;
    v_q     <= v_d;
    r_q     <= r_d;
    p1_v_q  <= p1_v_d;
    u_q     <= u_d;
    du_q    <= du_d;
    best_q  <= best_d;
    cand_q  <= cand_d;
    total_q <= total_d;
    x_q     <= x_d;
    n_q     <= n_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
  end

  // Distance, predecessor and path stack stores
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (dist_re) dist_rd_q <= dist_mem[dist_raddr];
    if (pred_we) pred_mem[pred_waddr] <= pred_wdata;
    if (pred_re) pred_rd_q <= pred_mem[x_q];
    if (stack_we) stack_mem[stack_waddr] <= x_q;
    if (stack_re) stack_rd_q <= stack_mem[stack_raddr];
  end

  // The vertex being relaxed from is always marked visited
  a_u_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dgsp_pkg::ST_RELAX || state_q == dgsp_pkg::ST_DRAIN) |-> visited_q[u_q])
    else $error("relax source not visited");

  // Stage one only runs inside a round
  a_p1_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_q |-> (state_q == dgsp_pkg::ST_RELAX || state_q == dgsp_pkg::ST_DRAIN))
    else $error("relax stage active outside a round");

  // A pending result word holds until the output register takes it
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && !emit_take_i) |=> (emit_o.valid && $stable(emit_o.vertex)
                                        && $stable(emit_o.last)))
    else $error("result word changed before taken");

endmodule

>>> hdl/dense_graph_shortest_path_core.sv
`timescale 1ns / 1ps
// Top level of the dense graph shortest path core: config register,
// output register and the instances. Depends on dgsp_pkg, dgsp_adj_mem,
// dgsp_relax_unit and dgsp_seq.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one request word:
//    set edge (both directions, weight 0 removes it), clear all edges,
//    or a shortest path query from vertex_a_i to vertex_b_i.
//  - Output channel (out_valid_o / out_stall_i) returns the path vertices
//    of a query, source first, each word carrying the total distance;
//    last_o marks the final word. An unreachable query gives one word
//    with reachable_o low. Set and clear give no words.
//  - Config channel (cfg_valid_i / cfg_ready_o) writes the active vertex
//    count; write it only while the core is idle.
//  - A set writes both matrix entries; a clear runs the adjacency sweep
//    over every matrix entry. A query search is bounded by the single
//    shared relax unit reading one matrix entry per cycle; the path is
//    then traced back from the destination and emitted one word per vertex.
//  - Reset runs the same sweep with in_stall_o high.
//  - The output register frees the sequencer: a stalled final word does not
//    block the next request; a stalled middle word pauses the emission.

module dense_graph_shortest_path_core #(
  parameter int NUM_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_active_vertices_i,
  // requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  vertex_a_i,
  input  logic [3:0]  vertex_b_i,
  input  logic [15:0] weight_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  path_vertex_o,
  output logic [19:0] total_distance_o,
  output logic        reachable_o,
  output logic        last_o
);

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int SW = (WEIGHT_BITS < dgsp_pkg::PORT_WEIGHT_BITS) ? WEIGHT_BITS
                                                                  : dgsp_pkg::PORT_WEIGHT_BITS;

  logic [dgsp_pkg::ACTIVE_BITS-1:0] active_q;

  logic            adj_busy, adj_clr, adj_we, adj_re;
  logic [2*VW-1:0] adj_waddr, adj_raddr;
  logic [SW-1:0]   adj_wdata, adj_rdata;

  dgsp_pkg::emit_t emit;
  logic            out_free;
  logic            out_valid_q;
  logic [3:0]      vertex_q;
  logic [19:0]     dist_q;
  logic            reach_q, last_q;

  // Active vertex count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= dgsp_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_active_vertices_i;
    end
  end

  dgsp_adj_mem #(
    .VW (VW),
    .WB (SW)
  ) u_adj_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_start_i (adj_clr),
    .busy_o      (adj_busy),
    .we_i        (adj_we),
    .waddr_i     (adj_waddr),
    .wdata_i     (adj_wdata),
    .re_i        (adj_re),
    .raddr_i     (adj_raddr),
    .rdata_o     (adj_rdata)
  );

  dgsp_seq #(
    .NUM_VERTICES (NUM_VERTICES),
    .WB           (SW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .active_i    (active_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .weight_i    (weight_i),
    .adj_busy_i  (adj_busy),
    .adj_clr_o   (adj_clr),
    .adj_we_o    (adj_we),
    .adj_waddr_o (adj_waddr),
    .adj_wdata_o (adj_wdata),
    .adj_re_o    (adj_re),
    .adj_raddr_o (adj_raddr),
    .adj_rdata_i (adj_rdata),
    .emit_o      (emit),
    .emit_take_i (out_free)
  );

  // Output register: loads when empty or when its word leaves this cycle
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      vertex_q <= emit.vertex;
      dist_q   <= emit.total;
      reach_q  <= emit.reach;
      last_q   <= emit.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign path_vertex_o    = vertex_q;
  assign total_distance_o = dist_q;
  assign reachable_o      = reach_q;
  assign last_o           = last_q;

  // An unreachable word is always the only, final word at infinity
  a_miss_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reachable_o) |-> (last_o && total_distance_o == dgsp_pkg::DIST_INF))
    else $error("unreachable word malformed");

  // No request is taken while the adjacency sweep runs
  a_sweep_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adj_busy |-> in_stall_o)
    else $error("request accepted during adjacency sweep");

endmodule

>>> tb/tb_dense_graph_shortest_path_core.sv
`timescale 1ns / 1ps
// Testbench for dense_graph_shortest_path_core: random and directed edge, clear and
// path query words, with a scoreboard that predicts every path word.
// Depends on dgsp_pkg and the core under hdl/.

// One expected or observed path word
typedef struct packed {
  logic [3:0]  vertex;
  logic [19:0] total;
  logic        reach;
  logic        last;
} path_word_t;

// Scoreboard: mirrors the adjacency matrix and active count, predicts path words
class path_scoreboard;
  logic [15:0] weight_mat [16][16];
  logic [4:0]  active_cnt;
  path_word_t  pending_q [$];
  int          errors;

  function new();
    clear_matrix();
    active_cnt = dgsp_pkg::ACTIVE_RESET;
    errors = 0;
  endfunction

  function void clear_matrix();
    foreach (weight_mat[i, j]) weight_mat[i][j] = '0;
  endfunction

  function void note_active(logic [4:0] cnt);
    active_cnt = cnt;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  function void push_word(logic [3:0] vertex, logic [19:0] total, logic reach, logic last);
    path_word_t pw;
    pw.vertex = vertex;
    pw.total  = total;
    pw.reach  = reach;
    pw.last   = last;
    pending_q = {pending_q, pw};
  endfunction

  // Note one accepted request word
  function void note_word(logic [1:0] rt, logic [3:0] a, logic [3:0] b, logic [15:0] w);
    case (rt)
      dgsp_pkg::REQ_SET: begin
        weight_mat[a][b] = w;
        weight_mat[b][a] = w;
      end
      dgsp_pkg::REQ_CLEAR: clear_matrix();
      dgsp_pkg::REQ_QUERY: trace_path(a, b);
      default: ;
    endcase
  endfunction

  // Dense Dijkstra over the active vertices, ties to the highest index
  function void trace_path(logic [3:0] src, logic [3:0] dst);
    logic [19:0] cost [16];
    bit          done [16];
    logic [3:0]  pred [16];
    logic [3:0]  trail [16];
    int          nv, r, v, u, n, k;
    logic [19:0] best;
    logic [20:0] sum;
    logic [15:0] wt;
    logic [3:0]  x;
    nv = active_cnt;
    if (nv < 1) nv = 1;
    if (nv > 16) nv = 16;
    if (src >= nv || dst >= nv) begin
      push_word(4'd0, dgsp_pkg::DIST_INF, 1'b0, 1'b1);
      return;
    end
    for (v = 0; v < nv; v++) begin
      cost[v] = dgsp_pkg::DIST_INF;
      done[v] = 1'b0;
      pred[v] = src;
    end
    cost[src] = '0;
    for (r = 0; r + 1 < nv; r++) begin
      best = dgsp_pkg::DIST_INF;
      u = 0;
      for (v = 0; v < nv; v++) begin
        if (!done[v] && cost[v] <= best) begin
          best = cost[v];
          u = v;
        end
      end
      done[u] = 1'b1;
      for (v = 0; v < nv; v++) begin
        wt = weight_mat[u][v];
        if (!done[v] && wt != 16'd0 && cost[u] != dgsp_pkg::DIST_INF) begin
          sum = {1'b0, cost[u]} + {5'd0, wt};
          if (sum > {1'b0, dgsp_pkg::DIST_INF}) sum = {1'b0, dgsp_pkg::DIST_INF};
          if (sum < {1'b0, cost[v]}) begin
            pred[v] = 4'(u);
            cost[v] = sum[19:0];
          end
        end
      end
    end
    if (cost[dst] == dgsp_pkg::DIST_INF) begin
      push_word(4'd0, dgsp_pkg::DIST_INF, 1'b0, 1'b1);
      return;
    end
    // walk predecessors back from the destination, emit source first
    n = 0;
    x = dst;
    while (n < nv) begin
      trail[n] = x;
      n++;
      if (x == src) break;
      x = pred[x];
    end
    for (k = 0; k < n; k++) push_word(trail[n - 1 - k], cost[dst], 1'b1, k == n - 1);
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Compare one accepted output word with the oldest expectation
  task check_word(logic [3:0] vertex, logic [19:0] total, logic reach, logic last);
    path_word_t want;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word vertex=%0d dist=%0d reach=%0b last=%0b",
                                vertex, total, reach, last));
      return;
    end
    want = pending_q.pop_front();
    if (vertex !== want.vertex || total !== want.total || reach !== want.reach ||
        last !== want.last)
      report_mismatch($sformatf(
        "got vertex=%0d dist=%0d reach=%0b last=%0b, want %0d %0d %0b %0b",
        vertex, total, reach, last, want.vertex, want.total, want.reach, want.last));
  endtask
endclass

module tb_dense_graph_shortest_path_core;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         SETTLE_CYCLES  = 400;
  localparam int         WATCHDOG_LIMIT = 6000;
  localparam int         PHASE_ITEMS    = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_active_vertices_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [3:0]  vertex_a_i;
  logic [3:0]  vertex_b_i;
  logic [15:0] weight_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  path_vertex_o;
  logic [19:0] total_distance_o;
  logic        reachable_o;
  logic        last_o;

  path_scoreboard sb;
  bit             quiet_run;
  int             cur_nv;
  int             active_plan [8] = '{1, 0, 31, 2, 5, 17, 9, 16};

  dense_graph_shortest_path_core #(
    .NUM_VERTICES(16),
    .WEIGHT_BITS (16)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_active_vertices_i(cfg_active_vertices_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .req_type_i           (req_type_i),
    .vertex_a_i           (vertex_a_i),
    .vertex_b_i           (vertex_b_i),
    .weight_i             (weight_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .path_vertex_o        (path_vertex_o),
    .total_distance_o     (total_distance_o),
    .reachable_o          (reachable_o),
    .last_o               (last_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Send one request word; hold it until accepted, optional idle gap first
  task automatic send_word(input logic [1:0] rt, input logic [3:0] a, input logic [3:0] b,
                           input logic [15:0] w);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    vertex_a_i <= a;
    vertex_b_i <= b;
    weight_i   <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_word(rt, a, b, w);
  endtask

  // Drop valid, wait for all path words, then let trailing work finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [4:0] cnt);
    cfg_valid_i           <= 1'b1;
    cfg_active_vertices_i <= cnt;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.note_active(cnt);
    cfg_valid_i <= 1'b0;
    cur_nv = (cnt == 5'd0) ? 1 : ((cnt > 5'd16) ? 16 : int'(cnt));
  endtask

  // Mostly inside the active range, sometimes anywhere
  function automatic logic [3:0] pick_vertex();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, cur_nv - 1));
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF - 16'($urandom_range(0, 15));
      2, 3: return 16'($urandom_range(1, 20));
      default: return 16'($urandom());
    endcase
  endfunction

  // Random part: graph-building bursts followed by queries, plus raw noise
  task automatic run_random(input int target);
    int         counted, k, nsets, nq;
    logic [1:0] rt;
    counted = 0;
    while (counted < target) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 5) == 0) begin
          send_word(dgsp_pkg::REQ_CLEAR, 4'($urandom()), 4'($urandom()), 16'($urandom()));
          counted++;
        end
        nsets = $urandom_range(1, 10);
        for (k = 0; k < nsets; k++) begin
          send_word(dgsp_pkg::REQ_SET, pick_vertex(), pick_vertex(), pick_weight());
          counted++;
        end
        nq = $urandom_range(1, 4);
        for (k = 0; k < nq; k++) begin
          send_word(dgsp_pkg::REQ_QUERY, pick_vertex(), pick_vertex(), 16'($urandom()));
          counted++;
        end
      end else begin
        rt = 2'($urandom_range(0, 3));
        send_word(rt, 4'($urandom()), 4'($urandom()), 16'($urandom()));
        if (rt != REQ_UNUSED) counted++;
      end
    end
  endtask

  // Output stall bursts, with long stretches of none
  initial begin
    out_stall_i = 1'b0;
    forever begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(40, 120)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!quiet_run && $urandom_range(0, 1) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_word(path_vertex_o, total_distance_o, reachable_o, last_o);
  end

  // Watchdog on cycles with no handshake at all
  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o === 1'b1))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("tb_dense_graph_shortest_path_core: FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    int p;
    rst_ni                = 1'b0;
    cfg_valid_i           = 1'b0;
    cfg_active_vertices_i = 5'd0;
    in_valid_i            = 1'b0;
    req_type_i            = dgsp_pkg::REQ_SET;
    vertex_a_i            = 4'd0;
    vertex_b_i            = 4'd0;
    weight_i              = 16'd0;
    quiet_run             = 1'b0;
    cur_nv                = 16;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty graph, source equals destination
    send_word(dgsp_pkg::REQ_QUERY, 4'd0, 4'd15, 16'd0);
    send_word(dgsp_pkg::REQ_QUERY, 4'd7, 4'd7, 16'hFFFF);
    // max weight edge, self loop, a two-hop path
    send_word(dgsp_pkg::REQ_SET, 4'd0, 4'd1, 16'hFFFF);
    send_word(dgsp_pkg::REQ_SET, 4'd1, 4'd2, 16'd1);
    send_word(dgsp_pkg::REQ_SET, 4'd3, 4'd3, 16'd7);
    send_word(dgsp_pkg::REQ_QUERY, 4'd0, 4'd2, 16'd0);
    send_word(dgsp_pkg::REQ_QUERY, 4'd3, 4'd3, 16'd0);
    // equal-distance tie between two routes
    send_word(dgsp_pkg::REQ_SET, 4'd0, 4'd4, 16'd10);
    send_word(dgsp_pkg::REQ_SET, 4'd0, 4'd5, 16'd10);
    send_word(dgsp_pkg::REQ_SET, 4'd4, 4'd6, 16'd5);
    send_word(dgsp_pkg::REQ_SET, 4'd5, 4'd6, 16'd5);
    send_word(dgsp_pkg::REQ_QUERY, 4'd0, 4'd6, 16'd0);
    // top vertices, large sums
    send_word(dgsp_pkg::REQ_SET, 4'd15, 4'd14, 16'hFFFF);
    send_word(dgsp_pkg::REQ_SET, 4'd14, 4'd13, 16'hFFFF);
    send_word(dgsp_pkg::REQ_QUERY, 4'd15, 4'd13, 16'hFFFF);
    // weight zero removes an edge; unused request code is ignored
    send_word(dgsp_pkg::REQ_SET, 4'd1, 4'd2, 16'd0);
    send_word(dgsp_pkg::REQ_QUERY, 4'd0, 4'd2, 16'd0);
    send_word(REQ_UNUSED, 4'd15, 4'd15, 16'hFFFF);
    send_word(dgsp_pkg::REQ_SET, 4'd15, 4'd15, 16'd0);
    send_word(dgsp_pkg::REQ_SET, 4'd10, 4'd12, 16'h8000);
    send_word(dgsp_pkg::REQ_QUERY, 4'd12, 4'd10, 16'd0);
    // clear all, then everything is unreachable
    send_word(dgsp_pkg::REQ_CLEAR, 4'd15, 4'd0, 16'hFFFF);
    send_word(dgsp_pkg::REQ_QUERY, 4'd0, 4'd6, 16'd0);
    send_word(dgsp_pkg::REQ_QUERY, 4'd15, 4'd0, 16'd0);
    settle();

    // random phases over several active counts, the last one without idling
    for (p = 0; p < 8; p++) begin
      if (p == 7) quiet_run = 1'b1;
      write_active(5'(active_plan[p]));
      run_random(PHASE_ITEMS);
      settle();
    end

    if (sb.errors == 0)
      $display("tb_dense_graph_shortest_path_core: PASS");
    else
      $display("tb_dense_graph_shortest_path_core: FAIL");
    $finish;
  end

endmodule
